### rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the random permutation shuffler
// ----------------------------------------------------------------------------
package rps_pkg;

	localparam int MAX_ENTRIES_DEF = 64;    // default store depth
	localparam int DRAW_W          = 31;    // bits of one random draw
	localparam int SIZE_W          = 7;     // bits of the size register
	localparam int FIELD_W         = 6;     // bits of position and entry value
	localparam int DIV_CNT_W       = 5;     // counts the bit-serial modulo steps
	localparam int S_TDATA_W       = 32;
	localparam int M_TDATA_W       = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RDJ,
		ST_WRI,
		ST_WRJ,
		ST_OUT1,
		ST_LDL,
		ST_OUT2
	} rps_state_t;

endpackage

### rtl/random_permutation_shuffler.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// forward fisher-yates shuffle, one swap step per random draw beat
// ----------------------------------------------------------------------------
// sequence: a taken draw beat runs 31 restoring modulo steps in the shared
//   subtract/compare unit, then a read and two writes on the single write
//   port; a new draw beat is taken only after its result beats are taken
// reset: size 64, step 0, all valid bits cleared so the store reads as identity
module random_permutation_shuffler #(
	parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// draw input; s_tdata[30:0] random_draw, bit 31 zero
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rps_pkg::S_TDATA_W-1:0] s_tdata,
	// result output; m_tdata[5:0] position, [11:6] entry_value, [15:12] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rps_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	// size register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rps_pkg::SIZE_W-1:0]    cfg_data
);
	import rps_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW    = $clog2(MAX_ENTRIES + 1);
	localparam int CW    = (NW > SIZE_W) ? NW : SIZE_W;      // size arithmetic width
	localparam int SUM_W = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;
	localparam int EXT_W = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;

	rps_state_t state_q, state_d;

	// control registers
	logic [SIZE_W-1:0]    size_q;
	logic [IDX_W-1:0]     step_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MAX_ENTRIES-1:0] valid_q;     // entry written since last refill or size write

	// datapath registers
	logic [DRAW_W-1:0] draw_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] span_q;
	logic [IDX_W-1:0]  vi_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  out_pos_q;
	logic [IDX_W-1:0]  out_val_q;
	logic              out_last_q;

	// permutation store with registered read
	logic [IDX_W-1:0] mem [MAX_ENTRIES];
	logic [IDX_W-1:0] rd_data_q;
	logic             rd_valid_q;
	logic [IDX_W-1:0] rd_addr_q;

	// sequencer outputs
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] wr_data;
	logic             refill;

	// derived values
	logic [CW-1:0]     size_ext;
	logic [CW-1:0]     n_eff;
	logic [SIZE_W-1:0] span_d;
	logic [IDX_W-1:0]  nm1;
	logic              is_last;
	logic [IDX_W-1:0]  rd_val;
	logic [SIZE_W:0]   trial;
	logic              ge;
	logic [SIZE_W-1:0] rem_nx;
	logic [IDX_W-1:0]  j_d;
	logic              s_acc;
	logic              m_acc;
	logic [EXT_W-1:0]  pos_ext;
	logic [EXT_W-1:0]  val_ext;

	// effective size clamped to 2..MAX_ENTRIES
	always_comb begin
		size_ext = CW'(size_q);
		if (size_ext < CW'(2)) begin
			n_eff = CW'(2);
		end else if (size_ext > CW'(MAX_ENTRIES)) begin
			n_eff = CW'(MAX_ENTRIES);
		end else begin
			n_eff = size_ext;
		end
	end

	assign span_d  = SIZE_W'(n_eff - CW'(step_q));
	assign nm1     = IDX_W'(n_eff - CW'(1));
	assign is_last = (CW'(step_q) == (n_eff - CW'(2)));

	// unwritten entries read as their own index
	assign rd_val = rd_valid_q ? rd_data_q : rd_addr_q;

	// shared unit: one restoring modulo step per cycle
	assign trial  = {rem_q, draw_q[DRAW_W-1]};
	assign ge     = (trial >= {1'b0, span_q});
	assign rem_nx = ge ? SIZE_W'(trial - {1'b0, span_q}) : trial[SIZE_W-1:0];
	assign j_d    = IDX_W'(SUM_W'(rem_nx) + SUM_W'(step_q));

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// next state and memory control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		rd_addr  = step_q;
		wr_en    = 1'b0;
		wr_addr  = step_q;
		wr_data  = rd_val;
		refill   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(DRAW_W - 1)) begin
					state_d = ST_RDJ;
				end
			end
			ST_RDJ: begin
				rd_addr = j_q;
				state_d = ST_WRI;
			end
			ST_WRI: begin
				// entry i takes the value read from j
				wr_en   = 1'b1;
				wr_addr = step_q;
				wr_data = rd_val;
				state_d = ST_WRJ;
			end
			ST_WRJ: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = vi_q;
				state_d = ST_OUT1;
			end
			ST_OUT1: begin
				m_tvalid = 1'b1;
				rd_addr  = nm1;    // prefetch the tail entry for the closing step
				if (m_tready) begin
					state_d = is_last ? ST_LDL : ST_IDLE;
				end
			end
			ST_LDL: begin
				rd_addr = nm1;
				state_d = ST_OUT2;
			end
			ST_OUT2: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					refill  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: size, step, counter, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RESET;
			step_q  <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_valid) begin
				// a size write restarts the run
				size_q  <= cfg_data;
				step_q  <= '0;
				valid_q <= '0;
			end else if (refill) begin
				step_q  <= '0;
				valid_q <= '0;
			end else begin
				if (wr_en) begin
					valid_q[wr_addr] <= 1'b1;
				end
				if (state_q == ST_OUT1 && m_acc && !is_last) begin
					step_q <= step_q + IDX_W'(1);
				end
			end
			if (s_acc) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			draw_q <= s_tdata[DRAW_W-1:0];
			rem_q  <= '0;
			span_q <= span_d;
		end else if (state_q == ST_DIV) begin
			draw_q <= draw_q << 1;
			rem_q  <= rem_nx;
			if (cnt_q == '0) begin
				vi_q <= rd_val;     // entry i, read while idle
			end
			if (cnt_q == DIV_CNT_W'(DRAW_W - 1)) begin
				j_q <= j_d;
			end
		end
		if (state_q == ST_WRI) begin
			out_pos_q  <= step_q;
			out_val_q  <= rd_val;
			out_last_q <= 1'b0;
		end else if (state_q == ST_LDL) begin
			out_pos_q  <= nm1;
			out_val_q  <= rd_val;
			out_last_q <= 1'b1;
		end
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		rd_valid_q <= valid_q[rd_addr];
		rd_addr_q  <= rd_addr;
	end

	assign cfg_ready = 1'b1;

	assign pos_ext = EXT_W'(out_pos_q);
	assign val_ext = EXT_W'(out_val_q);
	assign m_tdata = {{(M_TDATA_W - 2*FIELD_W){1'b0}}, val_ext[FIELD_W-1:0],
		pos_ext[FIELD_W-1:0]};
	assign m_tlast = out_last_q;

endmodule

### bench/random_permutation_shuffler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_shuffler_checker
// watches the draw, result and size channels, keeps its own copy of the
// shuffle store and compares every result beat with the entry it predicts
// ----------------------------------------------------------------------------
module random_permutation_shuffler_checker #(
	parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata[30:0] random_draw, bit 31 pad
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [rps_pkg::S_TDATA_W-1:0] s_tdata,
	// m_tdata[5:0] position, [11:6] entry_value, [15:12] pad
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [rps_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          m_tlast,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rps_pkg::SIZE_W-1:0]    cfg_data,
	output int                            fail_count,
	output int                            due_count,
	output int                            draw_beats,
	output int                            result_beats,
	output int                            perms_done
);
	import rps_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] value;
		logic               last;
	} perm_entry_t;

	perm_entry_t        entries_due[$];
	logic [FIELD_W-1:0] perm_image [MAX_ENTRIES];
	logic [SIZE_W-1:0]  size_reg   = SIZE_RESET;
	int unsigned        slot       = 0;
	int                 mismatches = 0;
	int                 draws      = 0;
	int                 results    = 0;
	int                 closed     = 0;

	// size register clamped to the range the store supports
	function automatic int unsigned run_length(input logic [SIZE_W-1:0] sz);
		if (sz < 2)
			return 2;
		if (sz > MAX_ENTRIES)
			return MAX_ENTRIES;
		return 32'(sz);
	endfunction

	task automatic restart_run();
		for (int k = 0; k < MAX_ENTRIES; k++)
			perm_image[k] = FIELD_W'(k);
		slot = 0;
	endtask

	task automatic shuffle_step(input logic [DRAW_W-1:0] draw);
		int unsigned        n;
		int unsigned        span;
		int unsigned        j;
		logic [FIELD_W-1:0] held;
		n = run_length(size_reg);
		if (slot > n - 2)
			restart_run();
		span = n - slot;
		j = (draw % span) + slot;
		held = perm_image[slot];
		perm_image[slot] = perm_image[j];
		perm_image[j] = held;
		entries_due.push_back('{pos: FIELD_W'(slot), value: perm_image[slot], last: 1'b0});
		if (slot == n - 2) begin
			// closing step also settles the top entry
			entries_due.push_back('{pos: FIELD_W'(n - 1), value: perm_image[n - 1],
				last: 1'b1});
			closed++;
			restart_run();
		end else begin
			slot++;
		end
	endtask

	task automatic check_entry(input logic [FIELD_W-1:0] pos, input logic [FIELD_W-1:0] value,
			input logic last);
		perm_entry_t want;
		results++;
		if (entries_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result beat with nothing due: pos %0d value %0d last %0b",
					$realtime, pos, value, last);
			return;
		end
		want = entries_due.pop_front();
		if (want.pos !== pos || want.value !== value || want.last !== last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %0d mismatch: expected pos %0d value %0d last %0b,",
					$realtime, results, want.pos, want.value, want.last,
					" got pos %0d value %0d last %0b", pos, value, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = SIZE_RESET;
			restart_run();
			entries_due.delete();
			mismatches = 0;
			draws = 0;
			results = 0;
			closed = 0;
		end else begin
			// results first, so a beat never meets an entry pushed at the same edge
			if (m_tvalid && m_tready)
				check_entry(m_tdata[FIELD_W-1:0], m_tdata[2*FIELD_W-1:FIELD_W], m_tlast);
			if (cfg_valid && cfg_ready) begin
				size_reg = cfg_data;
				restart_run();
			end
			if (s_tvalid && s_tready) begin
				draws++;
				shuffle_step(s_tdata[DRAW_W-1:0]);
			end
		end
		fail_count   <= mismatches;
		due_count    <= entries_due.size();
		draw_beats   <= draws;
		result_beats <= results;
		perms_done   <= closed;
	end

endmodule

### bench/random_permutation_shuffler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_shuffler_tb
// drives random draw beats through the shuffler at many sizes and pacing
// modes; a checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module random_permutation_shuffler_tb;
	import rps_pkg::*;

	localparam int                   WATCHDOG_CYCLES = 1_000_000;
	localparam int                   HOLD_CYCLES     = 700;  // long sink hold-off
	localparam int                   TAIL_CYCLES     = 80;   // > one step latency
	localparam int                   ITEMS_PER_PACE  = 360;
	localparam logic [S_TDATA_W-1:0] DRAW_MAX        = 32'h7FFF_FFFF;
	localparam logic [S_TDATA_W-1:0] PAD_BIT         = 32'h8000_0000;

	// pacing of the two stream sides
	typedef enum int {
		PACE_SLOW_SINK,    // source gaps 7 %, sink stalls 88 %
		PACE_SLOW_SOURCE,  // source gaps 88 %, sink stalls 7 %
		PACE_FULL          // no gaps, no stalls
	} pace_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [SIZE_W-1:0]    cfg_data  = '0;

	pace_t pace_mode     = PACE_SLOW_SINK;
	logic  hold_toggle   = 1'b0;  // flipped to request one long sink hold-off
	logic  hold_seen     = 1'b0;
	int    hold_left     = 0;
	int    sizes_written = 0;

	int fail_count;
	int due_count;
	int draw_beats;
	int result_beats;
	int perms_done;

	random_permutation_shuffler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	random_permutation_shuffler_checker perm_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.due_count    (due_count),
		.draw_beats   (draw_beats),
		.result_beats (result_beats),
		.perms_done   (perms_done)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// sink side: random stalls by pacing mode, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_toggle) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (pace_mode)
				PACE_SLOW_SINK:   m_tready <= ($urandom_range(0, 99) >= 88);
				PACE_SLOW_SOURCE: m_tready <= ($urandom_range(0, 99) >= 7);
				default:          m_tready <= 1'b1;
			endcase
		end
	end

	// run is cut off at a generous cycle count
	initial begin
		repeat (WATCHDOG_CYCLES) @(posedge clk);
		$display("timeout: %0d results still due", due_count);
		$display("random_permutation_shuffler regression: fail");
		$finish;
	end

	// chance in percent that the source leaves a cycle empty
	function automatic int source_gap_pct();
		case (pace_mode)
			PACE_SLOW_SINK:   return 7;
			PACE_SLOW_SOURCE: return 88;
			default:          return 0;
		endcase
	endfunction

	// draws lean on the corners: zero, all ones, small values, pad bit set
	function automatic logic [S_TDATA_W-1:0] make_draw();
		int                   k;
		logic [S_TDATA_W-1:0] word;
		k = $urandom_range(0, 99);
		if (k < 6)
			word = '0;
		else if (k < 12)
			word = DRAW_MAX;
		else if (k < 20)
			word = $urandom_range(0, 130);
		else
			word = $urandom & DRAW_MAX;
		if ($urandom_range(0, 99) < 10)
			word = word | PAD_BIT;
		return word;
	endfunction

	// mostly small sizes, some up to full depth, a few out of range on either side
	function automatic logic [SIZE_W-1:0] pick_size();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return SIZE_W'($urandom_range(2, 8));
		if (k < 80)
			return SIZE_W'($urandom_range(9, 20));
		if (k < 90)
			return SIZE_W'($urandom_range(21, 64));
		if (k < 95)
			return SIZE_W'($urandom_range(65, 127));
		return SIZE_W'($urandom_range(0, 1));
	endfunction

	function automatic int run_length(input logic [SIZE_W-1:0] sz);
		if (sz < 2)
			return 2;
		if (sz > MAX_ENTRIES_DEF)
			return MAX_ENTRIES_DEF;
		return int'(sz);
	endfunction

	// one draw beat; tvalid stays high afterwards for a back-to-back beat
	task automatic send_draw(input logic [S_TDATA_W-1:0] word);
		while ($urandom_range(0, 99) < source_gap_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every predicted result beat has come
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	// size write, only issued while the block is idle
	task automatic write_size(input logic [SIZE_W-1:0] sz);
		cfg_valid <= 1'b1;
		cfg_data  <= sz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sizes_written++;
	endtask

	initial begin
		int                n_eff;
		int                runs;
		int                steps;
		int                mode_items;
		int                group;
		logic [SIZE_W-1:0] size_pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: partial run at the reset size of 64
		send_draw(32'd5);
		send_draw(DRAW_MAX);
		send_draw(PAD_BIT);
		drain_results();
		// smallest size, every beat closes a run with two results
		write_size(7'd2);
		send_draw('0);
		send_draw(DRAW_MAX);
		send_draw(32'hFFFF_FFFF);
		drain_results();
		// sizes below the range clamp to two
		write_size(7'd0);
		send_draw(32'd3);
		drain_results();
		write_size(7'd1);
		send_draw(PAD_BIT | 32'd1);
		drain_results();
		// size three, two full runs
		write_size(7'd3);
		send_draw(32'd0);
		send_draw(32'd1);
		send_draw(32'd2);
		send_draw(DRAW_MAX);
		drain_results();
		// full depth, then sizes above the range clamp to full depth
		write_size(7'd64);
		send_draw(DRAW_MAX);
		send_draw(32'd63);
		send_draw(32'd0);
		drain_results();
		write_size(7'd65);
		send_draw(32'd1);
		send_draw(32'd64);
		drain_results();
		write_size(7'd127);
		send_draw(32'hFFFF_FFFF);
		send_draw(32'd5);
		drain_results();

		// random: mostly complete runs, sometimes cut short by a size write
		for (int p = 0; p < 3; p++) begin
			pace_mode = pace_t'(p);
			mode_items = 0;
			group = 0;
			while (mode_items < ITEMS_PER_PACE) begin
				size_pick = pick_size();
				// long sink hold-off on a mid-sized run with the source pushing hard
				if (pace_mode == PACE_FULL && group == 0)
					size_pick = 7'd24;
				write_size(size_pick);
				if (pace_mode == PACE_FULL && group == 0)
					hold_toggle <= ~hold_toggle;
				n_eff = run_length(size_pick);
				runs = (n_eff > 20) ? 1 : $urandom_range(1, 4);
				for (int r = 0; r < runs; r++) begin
					steps = n_eff - 1;
					if ($urandom_range(0, 99) < 15)
						steps = $urandom_range(1, steps);
					for (int s = 0; s < steps; s++) begin
						send_draw(make_draw());
						mode_items++;
						// occasional pause mid-run until the output is empty
						if ($urandom_range(0, 99) < 3)
							drain_results();
					end
				end
				drain_results();
				group++;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d draw beats, %0d result beats, %0d closed permutations,",
			draw_beats, result_beats, perms_done, " %0d size writes", sizes_written);
		$display("sizes 0 to 127 incl. clamped ones, three pacing modes, one long sink hold-off");
		if (fail_count == 0) begin
			$display("random_permutation_shuffler regression: pass");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("random_permutation_shuffler regression: fail");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/rps_pkg.sv
rtl/random_permutation_shuffler.sv
bench/random_permutation_shuffler_checker.sv
bench/random_permutation_shuffler_tb.sv
